[rtl/utf8_to_utf16_transcoder_macros.svh]
// Assertion helpers used by the checker module.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define U8U16_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define U8U16_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 check failed");

`endif

[rtl/u8u16_pkg.sv]
`timescale 1ns / 1ps

package u8u16_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DRAIN
    } state_t;

    // Register indexes on the configuration channel
    localparam logic CFG_UTF8_MODE   = 1'b0;
    localparam logic CFG_STRICT_MODE = 1'b1;

    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [10:0] CP_MIN2      = 11'h080;
    localparam logic [15:0] CP_MIN3      = 16'h0800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    // Top five bits of an encoded surrogate, U+D800..U+DFFF
    localparam logic [4:0]  SURR_TOP     = 5'b11011;

    // Outcome of decoding one sequence at the head of the window
    typedef struct packed {
        logic        wait_more;  // sequence incomplete, string continues
        logic        fault;      // invalid sequence, units hold U+FFFD
        logic [2:0]  step;       // bytes consumed
        logic        pair;       // two units (surrogate pair)
        logic [15:0] unit0;
        logic [15:0] unit1;
    } dec_t;

endpackage

[rtl/utf8_to_utf16_transcoder.sv]
`timescale 1ns / 1ps
// UTF-8 to UTF-16 transcoder.
// Input stream: one byte per transfer on s_tdata, s_tlast marks the last byte
// of a string. Output stream: one UTF-16 code unit per transfer on m_tdata,
// m_tuser flags a string that strict mode rejected (code unit zero), m_tlast
// marks the final result of a string. The config channel writes utf8_mode
// (index 0) and strict_mode (index 1); write it only while the block is idle.
// Each input byte is handled on its own: the block takes it, the shared
// sequence decoder passes over the head of the window (a complete, an invalid
// or a still incomplete sequence) until the byte's work is done, each result
// is delivered, and the block returns to idle. The decoder is not used in
// widening mode or after a strict fault; the single decoder is used once per
// cycle while the window is decoded.
// Results of one byte are gathered in a four-entry buffer before delivery, so
// a strict-mode fault on the last byte replaces them with the error mark.
// s_tready is low while a byte is in work; when the receiver stalls the
// current result holds on m_tdata and the block waits.
// Reset clears the held-byte count, the error flag and both mode registers,
// and leaves the block idle and ready.

module utf8_to_utf16_transcoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_unit
    output logic        m_tuser,    // [0] bad_string
    output logic        m_tlast,    // last_unit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import u8u16_pkg::*;

    state_t      state_reg, state_next;
    logic [7:0]  win_reg [4];
    logic [7:0]  win_next [4];
    logic [2:0]  rem_reg, rem_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        error_seen_reg, error_seen_next;
    logic        eos_reg, eos_next;
    logic [15:0] res_reg [4];
    logic [15:0] res_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  rd_reg, rd_next;
    logic        utf8_mode_reg;
    logic        strict_mode_reg;
    logic        drain_err;
    logic [2:0]  total;
    logic [2:0]  cnt_one;
    dec_t        dec;

    u8u16_seq_decoder u_dec
    (
        .win (({win_reg[3], win_reg[2], win_reg[1], win_reg[0]})),
        .rem (rem_reg),
        .eos (eos_reg),
        .dec (dec)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf8_mode_reg   <= 1'b0;
            strict_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_UTF8_MODE:   utf8_mode_reg   <= cfg_data;
                CFG_STRICT_MODE: strict_mode_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // The error flag stays set through delivery, so the mark is known here
    assign drain_err = eos_reg && error_seen_reg;
    assign total     = drain_err ? 3'd1 : cnt_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DRAIN) && (rd_reg < total);
    assign m_tdata  = drain_err ? 16'h0000 : res_reg[rd_reg[1:0]];
    assign m_tuser  = drain_err;
    assign m_tlast  = eos_reg && (rd_reg == total - 3'd1);

    always_comb
    begin
        state_next      = state_reg;
        win_next        = win_reg;
        rem_next        = rem_reg;
        held_count_next = held_count_reg;
        error_seen_next = error_seen_reg;
        eos_next        = eos_reg;
        res_next        = res_reg;
        cnt_next        = cnt_reg;
        rd_next         = rd_reg;
        cnt_one         = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    eos_next = s_tlast;
                    cnt_next = 3'd0;
                    rd_next  = 3'd0;
                    if (error_seen_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else if (!utf8_mode_reg)
                    begin
                        // Widen; held bytes stay untouched
                        res_next[0] = {8'h00, s_tdata};
                        cnt_next    = 3'd1;
                        state_next  = ST_DRAIN;
                    end
                    else
                    begin
                        win_next[held_count_reg] = s_tdata;
                        rem_next   = {1'b0, held_count_reg} + 3'd1;
                        state_next = ST_DECODE;
                    end
                end
            end

            ST_DECODE:
            begin
                if (dec.wait_more)
                begin
                    // Bytes left at the head of the window are the held bytes
                    held_count_next = rem_reg[1:0];
                    state_next      = ST_DRAIN;
                end
                else if (dec.fault && strict_mode_reg)
                begin
                    error_seen_next = 1'b1;
                    held_count_next = 2'd0;
                    state_next      = ST_DRAIN;
                end
                else
                begin
                    if (cnt_reg < 3'd4)
                    begin
                        res_next[cnt_reg[1:0]] = dec.unit0;
                        cnt_one = cnt_reg + 3'd1;
                    end
                    cnt_next = cnt_one;
                    if (dec.pair && (cnt_one < 3'd4))
                    begin
                        res_next[cnt_one[1:0]] = dec.unit1;
                        cnt_next = cnt_one + 3'd1;
                    end
                    case (dec.step)
                        3'd1:
                        begin
                            win_next[0] = win_reg[1];
                            win_next[1] = win_reg[2];
                            win_next[2] = win_reg[3];
                        end
                        3'd2:
                        begin
                            win_next[0] = win_reg[2];
                            win_next[1] = win_reg[3];
                        end
                        3'd3:
                        begin
                            win_next[0] = win_reg[3];
                        end
                        default: ;
                    endcase
                    rem_next = rem_reg - dec.step;
                    if (rem_reg == dec.step)
                    begin
                        held_count_next = 2'd0;
                        state_next      = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (rd_reg == total)
                begin
                    if (eos_reg)
                    begin
                        held_count_next = 2'd0;
                        error_seen_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
                else if (m_tready)
                begin
                    rd_next = rd_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rem_reg        <= 3'd0;
            held_count_reg <= 2'd0;
            error_seen_reg <= 1'b0;
            eos_reg        <= 1'b0;
            cnt_reg        <= 3'd0;
            rd_reg         <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            rem_reg        <= rem_next;
            held_count_reg <= held_count_next;
            error_seen_reg <= error_seen_next;
            eos_reg        <= eos_next;
            cnt_reg        <= cnt_next;
            rd_reg         <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        res_reg <= res_next;
    end

endmodule

[rtl/u8u16_seq_decoder.sv]
`timescale 1ns / 1ps

module u8u16_seq_decoder
(
    input  logic [31:0]        win,   // byte 0 in the lowest bits
    input  logic [2:0]         rem,   // valid bytes in win
    input  logic               eos,
    output u8u16_pkg::dec_t    dec
);
    import u8u16_pkg::*;

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  need;
    logic        lead_ok;
    logic        short_seq;
    logic        chk;
    logic        good;
    logic        c1, c2, c3;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [20:0] v;
    logic [15:0] good_unit0;
    logic [15:0] good_unit1;
    logic        good_pair;

    assign b0 = win[7:0];
    assign b1 = win[15:8];
    assign b2 = win[23:16];
    assign b3 = win[31:24];

    assign c1 = (b1[7:6] == 2'b10);
    assign c2 = (b2[7:6] == 2'b10);
    assign c3 = (b3[7:6] == 2'b10);

    assign cp2 = {b0[4:0], b1[5:0]};
    assign cp3 = {b0[3:0], b1[5:0], b2[5:0]};
    assign cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    assign v   = cp4 - CP_MIN4;

    always_comb
    begin
        lead_ok    = 1'b1;
        chk        = 1'b1;
        need       = 3'd1;
        good_pair  = 1'b0;
        good_unit0 = {8'h00, b0};
        good_unit1 = LO_SURR_BASE + {6'b0, v[9:0]};
        casez (b0)
            8'b0???????:
            begin
                need = 3'd1;
            end
            8'b110?????:
            begin
                need       = 3'd2;
                chk        = c1 && (cp2 >= CP_MIN2);
                good_unit0 = {5'b0, cp2};
            end
            8'b1110????:
            begin
                need       = 3'd3;
                chk        = c1 && c2 && (cp3 >= CP_MIN3) && (cp3[15:11] != SURR_TOP);
                good_unit0 = cp3;
            end
            8'b11110???:
            begin
                need       = 3'd4;
                chk        = c1 && c2 && c3 && (cp4 >= CP_MIN4) && (cp4 <= CP_MAX);
                good_pair  = 1'b1;
                good_unit0 = HI_SURR_BASE + {6'b0, v[19:10]};
            end
            default:
            begin
                lead_ok = 1'b0;
                need    = 3'd1;
            end
        endcase
    end

    assign short_seq = lead_ok && (rem < need);
    assign good      = lead_ok && !short_seq && chk;

    always_comb
    begin
        dec.wait_more = short_seq && !eos;
        dec.fault     = !good && !(short_seq && !eos);
        if (good)
        begin
            dec.step  = need;
            dec.pair  = good_pair;
            dec.unit0 = good_unit0;
            dec.unit1 = good_unit1;
        end
        else
        begin
            // Substitute and resume one byte after the lead
            dec.step  = 3'd1;
            dec.pair  = 1'b0;
            dec.unit0 = REPL_CHAR;
            dec.unit1 = REPL_CHAR;
        end
    end

endmodule

[rtl/u8u16_checker.sv]
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result holds
    `U8U16_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One byte in work at a time: no intake while results are pending
    `U8U16_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready)

    // After an input transfer the block is busy
    `U8U16_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

    // The error mark is the string's final result and carries no unit
    `U8U16_ASSERT_NOW(a_err_mark, m_tvalid && m_tuser, m_tlast && (m_tdata == 16'h0000))

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);
